>>> hdl/psis_pkg.sv
// Shared types and constants for the partial shuffle index sampler.
// Used by the sampler top level and its divider; depends on nothing.
package psis_pkg;

   // Fixed field widths of the command, result and CSR words
   localparam int WORD_W    = 31;
   localparam int CFG_W     = 11;
   localparam int OUT_IDX_W = 10;
   localparam int CSR_IDX_W = 2;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ARRAY_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_LENGTH  = 2'd1;

   // Both CSRs come out of reset at 1024
   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   // Run epoch tag kept next to every pool entry; tag zero means never written
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_READ_SLOT,
      ST_READ_TAIL,
      ST_UPDATE
   } state_type;

endpackage

>>> hdl/partial_shuffle_index_sampler.sv
// Partial shuffle index sampler: draws distinct pool indices without replacement.
// Start is accepted only while idle, so a new word waits until the last is done.
// The result channel has no ready; the receiver never stalls.
// A draw is a check, a pass through the remainder unit, two reads and one write on
// the pool RAM, and the idle accept step. A restart that wraps the 8-bit epoch adds
// a clearing pass over all MAX_POOL entries (every 255th). Reset (sync): the same pass, busy.
module partial_shuffle_index_sampler #(
   parameter int MAX_POOL = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             start,
   output logic                             busy,
   input  logic [psis_pkg::WORD_W-1:0]      req_random_word,
   input  logic                             req_restart,
   // result channel, one-cycle strobe, never stalled
   output logic                             rsp_valid,
   output logic [psis_pkg::OUT_IDX_W-1:0]   rsp_chosen_index,
   output logic                             rsp_last_of_run,
   output logic                             rsp_exhausted,
   // CSR write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psis_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psis_pkg::CFG_W-1:0]       csr_data
);

   localparam int IDX_W = $clog2(MAX_POOL);
   localparam int CNT_W = $clog2(MAX_POOL + 1);
   localparam int RAM_W = psis_pkg::EPOCH_W + IDX_W;

   // ------------------------------------------------------------------
   // State and registers
   // ------------------------------------------------------------------
   psis_pkg::state_type state_ff, state_in;

   logic [psis_pkg::CFG_W-1:0]   array_length_ff, array_length_in;
   logic [psis_pkg::CFG_W-1:0]   draw_length_ff, draw_length_in;
   logic [CNT_W-1:0]             remaining_ff, remaining_in;
   logic [CNT_W-1:0]             draws_ff, draws_in;
   logic [psis_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic                         pend_ff, pend_in;
   logic [IDX_W-1:0]             clr_ff, clr_in;
   logic [psis_pkg::WORD_W-1:0]  word_ff, word_in;
   logic [IDX_W-1:0]             slot_ff, slot_in;
   logic [IDX_W-1:0]             picked_ff, picked_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [psis_pkg::OUT_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_exh_ff, rsp_exh_in;

   // ------------------------------------------------------------------
   // Shared units: remainder divider and pool RAM {epoch tag, entry}
   // ------------------------------------------------------------------
   logic             div_start;
   logic             div_done;
   logic [CNT_W-1:0] div_rem;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [RAM_W-1:0] ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [RAM_W-1:0] ram_rd_data;

   psis_divider #(
      .DIV_W (CNT_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (word_ff),
      .divisor   (remaining_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   psis_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_POOL)
   ) u_pool (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Derived values
   // ------------------------------------------------------------------
   logic                         accept;
   logic                         nothing_left;
   logic                         clr_last;
   logic [CNT_W-1:0]             n_eff;
   logic [CNT_W-1:0]             d_eff;
   logic [IDX_W-1:0]             tail_addr;
   logic [psis_pkg::EPOCH_W-1:0] rd_tag;
   logic [IDX_W-1:0]             rd_val;
   logic                         rd_hit;
   logic [IDX_W-1:0]             tail_val;
   logic [31:0]                  picked_wide;

   assign accept       = start && (state_ff == psis_pkg::ST_IDLE);
   assign nothing_left = (draws_ff == '0) || (remaining_ff == '0);
   assign clr_last     = (clr_ff == IDX_W'(MAX_POOL - 1));
   assign tail_addr    = IDX_W'(remaining_ff - CNT_W'(1));
   assign rd_tag       = ram_rd_data[RAM_W-1:IDX_W];
   assign rd_val       = ram_rd_data[IDX_W-1:0];
   // an entry whose tag is not this run's epoch still holds its own index
   assign rd_hit       = (rd_tag == epoch_ff);
   assign tail_val     = rd_hit ? rd_val : tail_addr;
   assign picked_wide  = 32'(picked_ff);

   // saturate pool size at MAX_POOL, draw length at the pool size
   always_comb begin
      if (32'(array_length_ff) > MAX_POOL) begin
         n_eff = CNT_W'(MAX_POOL);
      end else begin
         n_eff = CNT_W'(array_length_ff);
      end
      if (32'(draw_length_ff) > 32'(n_eff)) begin
         d_eff = n_eff;
      end else begin
         d_eff = CNT_W'(draw_length_ff);
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psis_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = pend_ff ? psis_pkg::ST_CHECK : psis_pkg::ST_IDLE;
            end
         end
         psis_pkg::ST_IDLE: begin
            if (accept) begin
               // a restart that wraps the epoch must clear stale tags first
               if (req_restart && (epoch_ff == psis_pkg::EPOCH_LAST)) begin
                  state_in = psis_pkg::ST_CLEAR;
               end else begin
                  state_in = psis_pkg::ST_CHECK;
               end
            end
         end
         psis_pkg::ST_CHECK: begin
            state_in = nothing_left ? psis_pkg::ST_IDLE : psis_pkg::ST_DIVIDE;
         end
         psis_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = psis_pkg::ST_READ_SLOT;
            end
         end
         psis_pkg::ST_READ_SLOT: state_in = psis_pkg::ST_READ_TAIL;
         psis_pkg::ST_READ_TAIL: state_in = psis_pkg::ST_UPDATE;
         psis_pkg::ST_UPDATE:    state_in = psis_pkg::ST_IDLE;
         default:                state_in = psis_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: unit controls
   // ------------------------------------------------------------------
   always_comb begin
      busy        = (state_ff != psis_pkg::ST_IDLE);
      div_start   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = {epoch_ff, tail_val};
      ram_rd_addr = slot_ff;
      unique case (state_ff)
         psis_pkg::ST_CLEAR: begin
            // drop every tag to zero, which no run epoch uses
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         psis_pkg::ST_CHECK: begin
            div_start = !nothing_left;
         end
         psis_pkg::ST_READ_TAIL: begin
            ram_rd_addr = tail_addr;
         end
         psis_pkg::ST_UPDATE: begin
            // move the last live entry into the drawn slot
            ram_wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      array_length_in = array_length_ff;
      draw_length_in  = draw_length_ff;
      remaining_in    = remaining_ff;
      draws_in        = draws_ff;
      epoch_in        = epoch_ff;
      pend_in         = pend_ff;
      clr_in          = clr_ff;
      word_in         = word_ff;
      slot_in         = slot_ff;
      picked_in       = picked_ff;
      rsp_valid_in    = 1'b0;
      rsp_index_in    = rsp_index_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_exh_in      = rsp_exh_ff;

      // CSR writes; unknown indexes are ignored
      if (csr_valid) begin
         unique case (csr_index)
            psis_pkg::CSR_ARRAY_LENGTH: array_length_in = csr_data;
            psis_pkg::CSR_DRAW_LENGTH:  draw_length_in  = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         psis_pkg::ST_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_last) begin
               clr_in  = '0;
               pend_in = 1'b0;
            end
         end
         psis_pkg::ST_IDLE: begin
            if (accept) begin
               word_in = req_random_word;
               if (req_restart) begin
                  remaining_in = n_eff;
                  draws_in     = d_eff;
                  if (epoch_ff == psis_pkg::EPOCH_LAST) begin
                     epoch_in = psis_pkg::EPOCH_FIRST;
                     pend_in  = 1'b1;
                  end else begin
                     epoch_in = epoch_ff + psis_pkg::EPOCH_W'(1);
                  end
               end
            end
         end
         psis_pkg::ST_CHECK: begin
            if (nothing_left) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_last_in  = 1'b0;
               rsp_exh_in   = 1'b1;
            end
         end
         psis_pkg::ST_DIVIDE: begin
            if (div_done) begin
               slot_in = IDX_W'(div_rem);
            end
         end
         psis_pkg::ST_READ_TAIL: begin
            // slot word is on the read port now
            picked_in = rd_hit ? rd_val : slot_ff;
         end
         psis_pkg::ST_UPDATE: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = picked_wide[psis_pkg::OUT_IDX_W-1:0];
            rsp_last_in  = (draws_ff == CNT_W'(1));
            rsp_exh_in   = 1'b0;
            remaining_in = remaining_ff - CNT_W'(1);
            draws_in     = draws_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= psis_pkg::ST_CLEAR;
         array_length_ff <= psis_pkg::CFG_RESET;
         draw_length_ff  <= psis_pkg::CFG_RESET;
         remaining_ff    <= '0;
         draws_ff        <= '0;
         epoch_ff        <= psis_pkg::EPOCH_FIRST;
         pend_ff         <= 1'b0;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         array_length_ff <= array_length_in;
         draw_length_ff  <= draw_length_in;
         remaining_ff    <= remaining_in;
         draws_ff        <= draws_in;
         epoch_ff        <= epoch_in;
         pend_ff         <= pend_in;
         clr_ff          <= clr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      word_ff      <= word_in;
      slot_ff      <= slot_in;
      picked_ff    <= picked_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_exhausted    = rsp_exh_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == psis_pkg::ST_UPDATE ||
                        $past(state_ff) == psis_pkg::ST_CHECK))
      else $error("result word without a check or update step");

   a_draws_bounded: assert property (@(posedge clock) disable iff (reset)
      draws_ff <= remaining_ff)
      else $error("draws left exceed live pool entries");

   a_slot_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psis_pkg::ST_UPDATE) |-> (CNT_W'(slot_ff) < remaining_ff))
      else $error("drawn slot outside the live pool");

   a_exhausted_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exh_ff) |-> (rsp_index_ff == '0 && !rsp_last_ff))
      else $error("exhausted word carries an index or last flag");

endmodule

>>> hdl/psis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module psis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/psis_divider.sv
// Iterative remainder unit: dividend mod divisor, two restoring steps a cycle.
// Depends on psis_pkg for the dividend width.
module psis_divider #(
   parameter int DIV_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [psis_pkg::WORD_W-1:0] dividend,
   input  logic [DIV_W-1:0]           divisor,
   output logic                       done,
   output logic [DIV_W-1:0]           remainder
);

   localparam int STEPS = (psis_pkg::WORD_W + 1) / 2;
   localparam int PAD_W = 2 * STEPS;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PAD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] divisor_ff, divisor_in;

   always_comb begin
      logic [DIV_W-1:0] r;
      logic [DIV_W:0]   t;
      run_in     = run_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      r          = rem_ff;
      t          = '0;
      if (start) begin
         run_in     = 1'b1;
         cnt_in     = '0;
         dvd_in     = PAD_W'(dividend);
         rem_in     = '0;
         divisor_in = divisor;
      end else if (run_ff) begin
         // shift in two dividend bits, subtract where the partial remainder allows
         for (int k = 0; k < 2; k++) begin
            t = {r, dvd_ff[PAD_W-1-k]};
            if (t >= {1'b0, divisor_ff}) begin
               r = DIV_W'(t - {1'b0, divisor_ff});
            end else begin
               r = DIV_W'(t);
            end
         end
         rem_in = r;
         dvd_in = {dvd_ff[PAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("remainder not below divisor");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("divider done while still running");

endmodule

>>> sim/tb.sv
// Testbench for partial_shuffle_index_sampler: directed and random draws checked
// against an in-bench partial Fisher-Yates pool model. Depends on psis_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int POOL_DEPTH = 1024;

   localparam int WORD_W    = psis_pkg::WORD_W;
   localparam int CFG_W     = psis_pkg::CFG_W;
   localparam int OUT_IDX_W = psis_pkg::OUT_IDX_W;
   localparam int CSR_IDX_W = psis_pkg::CSR_IDX_W;

   // Spare CSR slots that the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

   typedef struct {
      logic [OUT_IDX_W-1:0] chosen_index;
      logic                 last_of_run;
      logic                 exhausted;
   } draw_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [WORD_W-1:0]    req_random_word = '0;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic [OUT_IDX_W-1:0] rsp_chosen_index;
   logic                 rsp_last_of_run;
   logic                 rsp_exhausted;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   // Pool model: entries, written marks, live count and draws left in the run
   logic [OUT_IDX_W-1:0] pool_entry [POOL_DEPTH];
   bit                   pool_written [POOL_DEPTH];
   int unsigned          live_count = 0;
   int unsigned          draws_pending = 0;
   // Register shadows; the block latches them only on a restart
   logic [CFG_W-1:0]     cfg_pool_size = psis_pkg::CFG_RESET;
   logic [CFG_W-1:0]     cfg_draw_count = psis_pkg::CFG_RESET;

   draw_result_type      expected_draws [$];
   int                   error_count = 0;
   int                   words_sent = 0;
   bit                   gaps_on = 1'b1;

   always #5 clock = ~clock;

   partial_shuffle_index_sampler #(
      .MAX_POOL(POOL_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_random_word  (req_random_word),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_exhausted    (rsp_exhausted),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Advance the pool model by one word and return the draw it must produce.
   // A restart latches the register shadows, clamps them and forgets all marks,
   // so every slot reads as its own index again.
   function automatic draw_result_type predict_draw(input logic [WORD_W-1:0] word,
                                                    input logic restart);
      draw_result_type      res;
      int unsigned          slot;
      int unsigned          tail_slot;
      logic [OUT_IDX_W-1:0] picked;
      logic [OUT_IDX_W-1:0] tail_val;
      if (restart) begin
         live_count    = (cfg_pool_size > POOL_DEPTH) ? POOL_DEPTH : cfg_pool_size;
         draws_pending = (cfg_draw_count > live_count) ? live_count : cfg_draw_count;
         pool_written  = '{default: 1'b0};
      end
      res.chosen_index = '0;
      res.last_of_run  = 1'b0;
      res.exhausted    = 1'b1;
      if (draws_pending != 0 && live_count != 0) begin
         slot      = word % live_count;
         tail_slot = live_count - 1;
         picked    = pool_written[slot] ? pool_entry[slot] : OUT_IDX_W'(slot);
         tail_val  = pool_written[tail_slot] ? pool_entry[tail_slot]
                                             : OUT_IDX_W'(tail_slot);
         // Move the last live entry into the slot just emptied
         pool_entry[slot]   = tail_val;
         pool_written[slot] = 1'b1;
         live_count--;
         draws_pending--;
         res.chosen_index = picked;
         res.last_of_run  = (draws_pending == 0);
         res.exhausted    = 1'b0;
      end
      return res;
   endfunction

   // Random word, weighted toward the extremes and small values
   function automatic logic [WORD_W-1:0] rand_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 9))
         0:       w = '0;
         1:       w = WORD_MAX;
         2:       w = WORD_W'($urandom_range(0, 2047));
         default: w = WORD_W'($urandom);
      endcase
      return w;
   endfunction

   // Drop start and hold it low for a delay given by n
   task automatic hold_off(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop start and wait until every expected draw is back and the block is idle
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_draws.size() != 0 || busy);
   endtask

   // Send one command word. Start stays high on return so that a following
   // word can go out back to back; anything else lowers it first.
   task automatic send_word(input logic [WORD_W-1:0] word, input logic restart);
      if (gaps_on) begin
         case ($urandom_range(0, 9))
            0, 1: hold_off($urandom_range(1, 5));
            2: begin
               // let the block go fully idle, then pause a little more
               drain_results();
               hold_off($urandom_range(1, 5));
            end
            default: ;
         endcase
      end
      start           <= 1'b1;
      req_random_word <= word;
      req_restart     <= restart;
      do @(posedge clock); while (busy);
      expected_draws = {expected_draws, predict_draw(word, restart)};
      words_sent++;
   endtask

   // Write one CSR; with more set, valid stays high for the next write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] data, input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == psis_pkg::CSR_ARRAY_LENGTH) cfg_pool_size = data;
      else if (idx == psis_pkg::CSR_DRAW_LENGTH) cfg_draw_count = data;
      if (!more) csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [CFG_W-1:0] pool_size,
                            input logic [CFG_W-1:0] draw_count);
      drain_results();
      write_csr(psis_pkg::CSR_ARRAY_LENGTH, pool_size, 1'b1);
      write_csr(psis_pkg::CSR_DRAW_LENGTH, draw_count, 1'b0);
   endtask

   // Check every result strobe against the oldest expected draw
   always @(posedge clock) begin
      draw_result_type exp_draw;
      if (!reset && rsp_valid) begin
         if (expected_draws.size() == 0) begin
            $error("unexpected result: chosen_index %0d last_of_run %0d exhausted %0d",
                   rsp_chosen_index, rsp_last_of_run, rsp_exhausted);
            error_count++;
         end else begin
            exp_draw = expected_draws.pop_front();
            if (rsp_chosen_index !== exp_draw.chosen_index) begin
               $error("chosen_index: expected %0d, got %0d",
                      exp_draw.chosen_index, rsp_chosen_index);
               error_count++;
            end
            if (rsp_last_of_run !== exp_draw.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      exp_draw.last_of_run, rsp_last_of_run);
               error_count++;
            end
            if (rsp_exhausted !== exp_draw.exhausted) begin
               $error("exhausted: expected %0d, got %0d",
                      exp_draw.exhausted, rsp_exhausted);
               error_count++;
            end
         end
      end
   end

   // After reset both counts are zero, so any draw is exhausted
   task automatic test_draw_before_restart();
      drain_results();
      send_word(WORD_MAX, 1'b0);
      send_word('0, 1'b0);
   endtask

   // The reset register values give a full 1024-entry pool; leave the run open
   task automatic test_reset_config();
      send_word(WORD_MAX, 1'b1);
      send_word('0, 1'b0);
      send_word(WORD_W'(1021), 1'b0);
   endtask

   // New register values must not touch the open run until the next restart
   task automatic test_write_mid_run();
      configure(11'd3, 11'd2047);
      send_word(WORD_W'(5), 1'b0);
      send_word(WORD_MAX, 1'b1);
      send_word(WORD_W'(1), 1'b0);
      send_word(WORD_MAX, 1'b0);
      send_word(WORD_W'(7), 1'b0);
   endtask

   // Pool of one: one draw ends the run, the next is exhausted, restart re-arms
   task automatic test_single_entry_pool();
      configure(11'd1, 11'd1024);
      send_word(WORD_MAX, 1'b1);
      send_word(WORD_MAX, 1'b0);
      send_word('0, 1'b1);
   endtask

   task automatic test_empty_pool();
      configure(11'd0, 11'd5);
      send_word(WORD_MAX, 1'b1);
   endtask

   // Pool size above the maximum saturates; a draw length of two ends the run, the next word is exhausted
   task automatic test_oversize_pool();
      configure(11'd2047, 11'd2);
      send_word(WORD_MAX, 1'b1);
      send_word(WORD_W'(1023), 1'b0);
      send_word(WORD_W'(1), 1'b0);
   endtask

   task automatic test_zero_draw_length();
      configure(11'd5, 11'd0);
      send_word(WORD_W'(3), 1'b1);
   endtask

   // Writes to the spare CSR indexes must be dropped
   task automatic test_ignored_index();
      drain_results();
      write_csr(CSR_SPARE_2, 11'd2047, 1'b1);
      write_csr(CSR_SPARE_3, 11'd0, 1'b0);
      send_word(WORD_W'(4), 1'b1);
      configure(11'd5, 11'd5);
      send_word(WORD_MAX, 1'b1);
      send_word(WORD_W'(2), 1'b0);
   endtask

   // Phases of random settings, each with one to six short runs. Most runs are
   // a restart followed by draws to the end; noise is a skipped restart, a
   // restart mid-run and up to two draws past the end.
   task automatic test_random_runs(input int n_words);
      int               stop_at;
      int               run_len;
      logic [CFG_W-1:0] pool_size;
      logic [CFG_W-1:0] draw_count;
      int               pick;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         case ($urandom_range(0, 19))
            0:       pool_size = '0;
            1:       pool_size = CFG_W'($urandom_range(POOL_DEPTH + 1, 2047));
            2:       pool_size = CFG_W'(POOL_DEPTH);
            3, 4, 5: pool_size = CFG_W'($urandom_range(17, POOL_DEPTH - 1));
            default: pool_size = CFG_W'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 9))
            0:       draw_count = '0;
            1:       draw_count = '1;
            2:       draw_count = CFG_W'($urandom_range(0, 2047));
            default: draw_count = CFG_W'($urandom_range(1, 17));
         endcase
         drain_results();
         pick = $urandom_range(0, 4);
         if (pick == 0) begin
            write_csr(psis_pkg::CSR_ARRAY_LENGTH, pool_size, 1'b0);
         end else if (pick == 1) begin
            write_csr(psis_pkg::CSR_DRAW_LENGTH, draw_count, 1'b0);
         end else begin
            write_csr(psis_pkg::CSR_ARRAY_LENGTH, pool_size, 1'b1);
            write_csr(psis_pkg::CSR_DRAW_LENGTH, draw_count, 1'b0);
         end
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 19) != 0) send_word(rand_word(), 1'b1);
            run_len = 0;
            while (draws_pending != 0 && live_count != 0 && run_len < 40) begin
               send_word(rand_word(), $urandom_range(0, 24) == 0);
               run_len++;
            end
            repeat ($urandom_range(0, 2)) send_word(rand_word(), 1'b0);
         end
      end
   endtask

   // Many restarts in a row so the run tag wraps and forces a clearing pass
   task automatic test_restart_storm(input int n_words);
      configure(CFG_W'($urandom_range(1, 32)), CFG_W'($urandom_range(1, 32)));
      repeat (n_words) send_word(rand_word(), $urandom_range(0, 5) != 0);
   endtask

   // Draw the whole 1024-entry pool back to back, then one past the end
   task automatic test_full_pool_run();
      configure(CFG_W'(POOL_DEPTH), CFG_W'(POOL_DEPTH));
      gaps_on = 1'b0;
      send_word(rand_word(), 1'b1);
      repeat (POOL_DEPTH) send_word(rand_word(), 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_draw_before_restart();
      test_reset_config();
      test_write_mid_run();
      test_single_entry_pool();
      test_empty_pool();
      test_oversize_pool();
      test_zero_draw_length();
      test_ignored_index();
      test_random_runs(450);
      test_restart_storm(260);
      test_full_pool_run();

      // Hold until the last draw is back, then watch for strays
      drain_results();
      repeat (25) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Bound the run: well above the slowest legal run, clearing passes included
   initial begin
      #(5_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
